/* hdl/pixel_level_curve_assert.svh */
// ----------------------------------------------------------------------------
// pixel_level_curve_assert.svh
// Assertion macros used by the checker of the pixel level curve.
// ----------------------------------------------------------------------------
`ifndef PIXEL_LEVEL_CURVE_ASSERT_SVH
`define PIXEL_LEVEL_CURVE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define PLC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pixel_level_curve assertion failed");

// Next-cycle implication, sampled on clk, off while in reset
`define PLC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pixel_level_curve assertion failed");

`endif

/* hdl/plc_pkg.sv */
// ----------------------------------------------------------------------------
// plc_pkg
// Types and constants of the pixel level curve pipeline.
// ----------------------------------------------------------------------------
package plc_pkg;

    localparam int PIX_W = 8;
    localparam int MID_W = 9;
    localparam int IDX_W = 2;

    localparam logic [PIX_W-1:0] FULL_SCALE = 8'd255;
    localparam logic [MID_W-1:0] Q_ONE      = 9'd256;

    localparam logic [PIX_W-1:0] RESET_LOW  = 8'd100;
    localparam logic [PIX_W-1:0] RESET_HIGH = 8'd165;
    localparam logic [MID_W-1:0] RESET_MID  = 9'd128;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_LOW  = 2'd0;
    localparam logic [IDX_W-1:0] REG_HIGH = 2'd1;
    localparam logic [IDX_W-1:0] REG_MID  = 2'd2;

    // pipeline stages end to end: setup 2, multiply 1, divide 4, output 1
    localparam int LATENCY = 8;

    // segment selected, ready for the multiply
    typedef struct packed {
        logic             bypass;
        logic [PIX_W-1:0] bypass_val;
        logic [PIX_W-1:0] base;
        logic [PIX_W-1:0] den;
        logic [PIX_W-1:0] offset;
        logic [PIX_W-1:0] span;
    } plc_seg_t;

    // divider state: partial remainder and dividend bits / quotient bits
    typedef struct packed {
        logic             bypass;
        logic [PIX_W-1:0] bypass_val;
        logic [PIX_W-1:0] base;
        logic [PIX_W-1:0] den;
        logic [PIX_W-1:0] rem;
        logic [PIX_W-1:0] work;
    } plc_div_t;

endpackage

/* hdl/plc_setup.sv */
// ----------------------------------------------------------------------------
// plc_setup
// Two stages: knee position and knee level, then segment selection.
// ----------------------------------------------------------------------------
module plc_setup
    import plc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [PIX_W-1:0] pixel,
    input  logic [PIX_W-1:0] low_lvl,
    input  logic [PIX_W-1:0] high_lvl,
    input  logic [MID_W-1:0] mid_pt,
    output logic             seg_valid,
    output plc_seg_t         seg
);

    // stage 1
    logic             v1_reg;
    logic [PIX_W-1:0] pix1_reg;
    logic [PIX_W-1:0] lo1_reg;
    logic [PIX_W-1:0] hi1_reg;
    logic [PIX_W-1:0] kx_off1_reg;
    logic [PIX_W-1:0] ky1_reg;
    logic             below1_reg;
    logic             above1_reg;

    logic [MID_W-1:0]     mid_sat;
    logic [PIX_W-1:0]     range;
    logic [PIX_W+MID_W-1:0] prod;
    logic [MID_W-1:0]     inv_mid;
    logic [MID_W+PIX_W-1:0] ky_full;

    always_comb
    begin
        mid_sat = (mid_pt > Q_ONE) ? Q_ONE : mid_pt;
        range   = high_lvl - low_lvl;
        prod    = {{MID_W{1'b0}}, range} * {{PIX_W{1'b0}}, mid_sat};
        inv_mid = Q_ONE - mid_sat;
        // 255 * x = (x << 8) - x
        ky_full = {inv_mid, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, inv_mid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        pix1_reg    <= pixel;
        lo1_reg     <= low_lvl;
        hi1_reg     <= high_lvl;
        kx_off1_reg <= prod[2*PIX_W-1:PIX_W];
        ky1_reg     <= ky_full[2*PIX_W-1:PIX_W];
        below1_reg  <= pixel < low_lvl;
        above1_reg  <= pixel > high_lvl;
    end

    // stage 2
    logic             v2_reg;
    plc_seg_t         seg_reg;
    plc_seg_t         seg_next;
    logic [PIX_W-1:0] knee_x;
    logic             lower;

    always_comb
    begin
        knee_x = lo1_reg + kx_off1_reg;
        lower  = pix1_reg < knee_x;
        seg_next.den    = lower ? (knee_x - lo1_reg) : (hi1_reg - knee_x);
        seg_next.offset = lower ? (pix1_reg - lo1_reg) : (pix1_reg - knee_x);
        seg_next.span   = lower ? ky1_reg : (FULL_SCALE - ky1_reg);
        seg_next.base   = lower ? '0 : ky1_reg;
        if (below1_reg)
        begin
            seg_next.bypass     = 1'b1;
            seg_next.bypass_val = '0;
        end
        else if (above1_reg)
        begin
            seg_next.bypass     = 1'b1;
            seg_next.bypass_val = FULL_SCALE;
        end
        else
        begin
            // flat segment: hold at the knee level
            seg_next.bypass     = (seg_next.den == '0);
            seg_next.bypass_val = ky1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        seg_reg <= seg_next;
    end

    assign seg_valid = v2_reg;
    assign seg       = seg_reg;

endmodule

/* hdl/plc_div_step.sv */
// ----------------------------------------------------------------------------
// plc_div_step
// One registered stage of the restoring divider, two quotient bits.
// ----------------------------------------------------------------------------
module plc_div_step
    import plc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  plc_div_t d_in,
    output logic     out_valid,
    output plc_div_t d_out
);

    localparam int STEPS = 2;

    logic     valid_reg;
    plc_div_t d_reg;
    plc_div_t d_next;

    always_comb
    begin
        logic [PIX_W:0] trial;
        logic           ge;
        d_next = d_in;
        for (int s = 0; s < STEPS; s++)
        begin
            // shift in the next dividend bit, subtract when it fits
            trial       = {d_next.rem, d_next.work[PIX_W-1]};
            ge          = trial >= {1'b0, d_next.den};
            d_next.rem  = ge ? PIX_W'(trial - {1'b0, d_next.den}) : trial[PIX_W-1:0];
            d_next.work = {d_next.work[PIX_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg <= d_next;
    end

    assign out_valid = valid_reg;
    assign d_out     = d_reg;

endmodule

/* hdl/pixel_level_curve.sv */
// ----------------------------------------------------------------------------
// pixel_level_curve
// Levels curve with a midpoint knee for an 8-bit grey pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive pixel_in with start high; a transaction is taken at each
//   rising edge where start is high and busy is low. busy stays low, so one
//   pixel per clock can enter, back to back.
//   Output: done pulses for one cycle with pixel_out valid; results come out
//   in input order, after passing through every pipeline register.
//   Throughput is one pixel per clock; the pipeline has two setup stages
//   (knee, segment select), one multiply stage, four divider stages of two
//   quotient bits each, and the output register.
//   Configuration: wr_en, wr_index, wr_data write low_level (0), high_level
//   (1) or mid_point (2) at a rising edge; other indexes are ignored.
//   Write only while no transaction is in flight.
//   Reset (rst_n low) empties the pipeline and restores low_level 100,
//   high_level 165, mid_point 128. The receiver cannot stall the output.
// ----------------------------------------------------------------------------
module pixel_level_curve
    import plc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [PIX_W-1:0] pixel_in,
    output logic             done,
    output logic [PIX_W-1:0] pixel_out,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_index,
    input  logic [MID_W-1:0] wr_data
);

    localparam int DIV_STAGES = 4;

    logic [PIX_W-1:0] low_level_reg;
    logic [PIX_W-1:0] high_level_reg;
    logic [MID_W-1:0] mid_point_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_level_reg  <= RESET_LOW;
            high_level_reg <= RESET_HIGH;
            mid_point_reg  <= RESET_MID;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_LOW:  low_level_reg  <= wr_data[PIX_W-1:0];
                REG_HIGH: high_level_reg <= wr_data[PIX_W-1:0];
                REG_MID:  mid_point_reg  <= wr_data;
                default:  ;
            endcase
        end
    end

    assign busy = 1'b0;

    logic     seg_valid;
    plc_seg_t seg;

    plc_setup u_setup (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start & ~busy),
        .pixel     (pixel_in),
        .low_lvl   (low_level_reg),
        .high_lvl  (high_level_reg),
        .mid_pt    (mid_point_reg),
        .seg_valid (seg_valid),
        .seg       (seg)
    );

    // multiply stage
    logic               mul_valid_reg;
    plc_div_t           mul_reg;
    plc_div_t           mul_next;
    logic [2*PIX_W-1:0] num;

    always_comb
    begin
        num                 = {{PIX_W{1'b0}}, seg.offset} * {{PIX_W{1'b0}}, seg.span};
        mul_next.bypass     = seg.bypass;
        mul_next.bypass_val = seg.bypass_val;
        mul_next.base       = seg.base;
        mul_next.den        = seg.den;
        // quotient fits 8 bits, so the high byte is already below den
        mul_next.rem        = num[2*PIX_W-1:PIX_W];
        mul_next.work       = num[PIX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
        end
        else
        begin
            mul_valid_reg <= seg_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_reg <= mul_next;
    end

    // divider pipeline
    logic     dv_valid [DIV_STAGES+1];
    plc_div_t dv       [DIV_STAGES+1];

    assign dv_valid[0] = mul_valid_reg;
    assign dv[0]       = mul_reg;

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        plc_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv_valid[g]),
            .d_in      (dv[g]),
            .out_valid (dv_valid[g+1]),
            .d_out     (dv[g+1])
        );
    end

    // output stage
    logic             done_reg;
    logic [PIX_W-1:0] pixel_out_reg;
    logic [PIX_W-1:0] pixel_out_next;
    logic [PIX_W:0]   sum;

    always_comb
    begin
        sum = {1'b0, dv[DIV_STAGES].base} + {1'b0, dv[DIV_STAGES].work};
        if (dv[DIV_STAGES].bypass)
        begin
            pixel_out_next = dv[DIV_STAGES].bypass_val;
        end
        else if (sum[PIX_W])
        begin
            pixel_out_next = FULL_SCALE;
        end
        else
        begin
            pixel_out_next = sum[PIX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_valid[DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_out_reg <= pixel_out_next;
    end

    assign done      = done_reg;
    assign pixel_out = pixel_out_reg;

endmodule

/* hdl/plc_checker.sv */
// ----------------------------------------------------------------------------
// plc_checker
// Port-level checks of the pixel level curve, bound to the top level.
// ----------------------------------------------------------------------------
`include "pixel_level_curve_assert.svh"

module plc_checker
    import plc_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    `PLC_ASSERT_IMP(a_never_busy, 1'b1, !busy)
    `PLC_ASSERT_IMP(a_accept_gives_result, start && !busy, ##LATENCY done)
    `PLC_ASSERT_IMP(a_result_has_source, done, $past(start && !busy, LATENCY))
    `PLC_ASSERT_IMP(a_quiet_after_reset, $rose(rst_n), !done)

endmodule

bind pixel_level_curve plc_checker u_plc_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
